### src/image_mse_psnr_metric_core_assert.svh
// Assertion macros shared by the image MSE and PSNR metric RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef IMAGE_MSE_PSNR_METRIC_CORE_ASSERT_SVH
`define IMAGE_MSE_PSNR_METRIC_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define IMSE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define IMSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define IMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/imse_pkg.sv
// Package for the image MSE and PSNR metric: shared widths and constants.
// Used by imse_mult, imse_divider and image_mse_psnr_metric_core.
`default_nettype none

package imse_pkg;

    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 56;
    localparam int MSE_W    = 32;
    localparam int PSNR_W   = 16;
    localparam int LOG_FRAC = 16;
    localparam int EXP_W    = 5;

    // 10*log10(2) in Q16.
    localparam logic [MUL_W-1:0] TEN_LOG10_2_Q16 = 32'd197283;

endpackage

`default_nettype wire

### src/imse_mult.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on imse_pkg for the operand and product widths.
`default_nettype none

module imse_mult
    import imse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [MUL_W-1:0]  op_a,
    input  wire logic [MUL_W-1:0]  op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### src/imse_divider.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// Depends on imse_pkg for the quotient width.
`default_nettype none

module imse_divider
    import imse_pkg::*;
#(
    parameter int NUM_W = 56,
    parameter int DEN_W = 23
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [MSE_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [MSE_W-1:0] quo_reg;
    logic             ovf_reg;

    logic [DEN_W:0]   rem_shift;
    logic             fits;
    logic [DEN_W:0]   rem_sub;

    // The partial remainder stays below the divisor, so one subtract per step.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numerator;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[MSE_W-2:0], fits};
            // Any quotient bit pushed past bit 31 means the mean does not fit.
            ovf_reg <= ovf_reg | quo_reg[MSE_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? '1 : quo_reg;

endmodule

`default_nettype wire

### src/image_mse_psnr_metric_core.sv
// Image MSE and PSNR metric, top level: sequencer, accumulators and log2 unit.
// Depends on imse_pkg, imse_mult, imse_divider and the assertion macro header.
//
//   channel  direction  handshake            payload
//   pix      in         pix_valid/pix_stall  expected_pixel, actual_pixel, last_pixel
//   res      out        res_valid/res_stall  mse_value, psnr_db, psnr_infinite,
//                                            range_error
//
// A pixel pair that is not last passes through accept, square and accumulate.
// A last pair adds a load step, the bit-serial divide of a NUM_W-bit numerator
// (NUM_W is 56 + max(0, 32 - 2*PIXEL_FRAC_BITS)), normalization, the 16 squaring
// steps of the log2, a scaling step and a delivery step.
// The shared multiplier and the bit-serial divider make these steps run in turn.
// Reset clears the accumulators, the sequencer and the result valid flag.
// A stalled result holds in the output register; the next image's pairs are
// still accepted meanwhile, and only the delivery step waits for a free slot.
`default_nettype none
`include "image_mse_psnr_metric_core_assert.svh"

module image_mse_psnr_metric_core
    import imse_pkg::*;
#(
    parameter int COUNT_BITS      = 22,
    parameter int PIXEL_FRAC_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pix_valid,
    output logic                            pix_stall,
    input  wire logic [PIXEL_FRAC_BITS:0]   expected_pixel,
    input  wire logic [PIXEL_FRAC_BITS:0]   actual_pixel,
    input  wire logic                       last_pixel,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic [MSE_W-1:0]                mse_value,
    output logic [PSNR_W-1:0]               psnr_db,
    output logic                            psnr_infinite,
    output logic                            range_error
);

    localparam int PIX_W = PIXEL_FRAC_BITS + 1;
    localparam int CNT_W = COUNT_BITS + 1;
    // The mean is sum * 2^(32 - 2F) / count; the scale is a shift either way.
    localparam int SHL   = (32 - 2 * PIXEL_FRAC_BITS > 0) ? 32 - 2 * PIXEL_FRAC_BITS : 0;
    localparam int SHR   = (2 * PIXEL_FRAC_BITS - 32 > 0) ? 2 * PIXEL_FRAC_BITS - 32 : 0;
    localparam int NUM_W = SUM_W + SHL;
    localparam int LOG_W = EXP_W + LOG_FRAC;
    localparam int NL_W  = LOG_W + 1;
    localparam int BIT_W = $clog2(LOG_FRAC);

    localparam logic [PIX_W-1:0] PIX_ONE = PIX_W'(1) << PIXEL_FRAC_BITS;
    localparam logic [NL_W-1:0]  LOG_TOP = NL_W'(32) << LOG_FRAC;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_SQUARE    = 10'b00_0000_0010,
        ST_ACCUM     = 10'b00_0000_0100,
        ST_DIV_LOAD  = 10'b00_0000_1000,
        ST_DIVIDE    = 10'b00_0001_0000,
        ST_NORM      = 10'b00_0010_0000,
        ST_SQR_MUL   = 10'b00_0100_0000,
        ST_SQR_CHK   = 10'b00_1000_0000,
        ST_SCALE_MUL = 10'b01_0000_0000,
        ST_DELIVER   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Accumulation state.
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               range_reg;
    logic [PIX_W-1:0]   diff_reg;
    logic               last_reg;

    // Result assembly.
    logic               flag_range_reg;
    logic               inf_reg;
    logic [MSE_W-1:0]   mse_reg;
    logic [PSNR_W-1:0]  psnr_reg;
    logic [MUL_W-1:0]   x_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               scale_pend_reg;

    // Output register.
    logic               res_valid_reg;
    logic [MSE_W-1:0]   res_mse_reg;
    logic [PSNR_W-1:0]  res_psnr_reg;
    logic               res_inf_reg;
    logic               res_range_reg;

    logic               pix_take;
    logic               res_take;
    logic               res_free;
    logic [PIX_W-1:0]   diff_abs;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;

    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [NUM_W-1:0]   numerator;
    logic               div_done;
    logic [MSE_W-1:0]   div_quot;

    logic [PROD_W-1:0]  sq_shift;
    logic [NL_W-1:0]    nl_value;
    logic [PROD_W-1:0]  psnr_round;
    logic [PROD_W-1:0]  psnr_full;
    logic [PSNR_W-1:0]  psnr_sat;

    assign pix_stall = (state_reg != ST_IDLE);
    assign pix_take  = pix_valid && !pix_stall;
    assign res_take  = res_valid_reg && !res_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    assign diff_abs = (expected_pixel >= actual_pixel) ? expected_pixel - actual_pixel
                                                        : actual_pixel - expected_pixel;

    // Saturating accumulate of the registered square.
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(prod);
    assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    assign numerator = (NUM_W'(sum_reg) << SHL) >> SHR;

    // One squaring step of the log2: x*x in Q2.62 back to Q2.31 (33 bits).
    assign sq_shift = prod >> (MUL_W - 1);

    // -log2(mse) relative to 2^32, then scaled by 10*log10(2) with rounding.
    assign nl_value   = LOG_TOP - NL_W'({exp_reg, frac_reg});
    assign psnr_round = prod + (PROD_W'(1) << 23);
    assign psnr_full  = psnr_round >> 24;
    assign psnr_sat   = (|psnr_full[PROD_W-1:PSNR_W]) ? '1 : psnr_full[PSNR_W-1:0];

    always_comb
    begin
        mul_a = x_reg;
        mul_b = x_reg;
        case (state_reg)
            ST_SQUARE:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = MUL_W'(diff_reg);
            end
            ST_SCALE_MUL:
            begin
                mul_a = MUL_W'(nl_value);
                mul_b = TEN_LOG10_2_Q16;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    imse_mult u_mult (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    imse_divider #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_DIV_LOAD),
        .numerator (numerator),
        .divisor   (count_reg),
        .done      (div_done),
        .quotient  (div_quot)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_take)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = last_reg ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    // A zero mean has no logarithm: infinite PSNR, report 0.
                    state_next = (div_quot == '0) ? ST_DELIVER : ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (x_reg[MUL_W-1])
                begin
                    state_next = ST_SQR_MUL;
                end
            end
            ST_SQR_MUL:
            begin
                state_next = ST_SQR_CHK;
            end
            ST_SQR_CHK:
            begin
                state_next = (bit_reg == '0) ? ST_SCALE_MUL : ST_SQR_MUL;
            end
            ST_SCALE_MUL:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                // The scaled product lands in the cycle after ST_SCALE_MUL.
                if (res_free && !scale_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sum_reg        <= '0;
            count_reg      <= '0;
            range_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            scale_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scale_pend_reg <= (state_reg == ST_SCALE_MUL);

            if (pix_take)
            begin
                if (!count_reg[CNT_W-1])
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if ((expected_pixel > PIX_ONE) || (actual_pixel > PIX_ONE))
                begin
                    range_reg <= 1'b1;
                end
            end

            if (state_reg == ST_ACCUM)
            begin
                sum_reg <= sum_sat;
            end

            // The divider captures sum and count at this edge; the image is done.
            if (state_reg == ST_DIV_LOAD)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                range_reg <= 1'b0;
            end

            if ((state_reg == ST_DELIVER) && res_free && !scale_pend_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            diff_reg <= diff_abs;
            last_reg <= last_pixel;
        end

        if (state_reg == ST_DIV_LOAD)
        begin
            flag_range_reg <= range_reg;
        end

        if ((state_reg == ST_DIVIDE) && div_done)
        begin
            mse_reg  <= div_quot;
            x_reg    <= div_quot;
            inf_reg  <= (div_quot == '0);
            exp_reg  <= EXP_W'(MUL_W - 1);
            frac_reg <= '0;
            bit_reg  <= BIT_W'(LOG_FRAC - 1);
            psnr_reg <= '0;
        end

        // Shift the mantissa up to Q1.31; the exponent is the top bit index.
        if ((state_reg == ST_NORM) && !x_reg[MUL_W-1])
        begin
            x_reg   <= {x_reg[MUL_W-2:0], 1'b0};
            exp_reg <= exp_reg - 1'b1;
        end

        if (state_reg == ST_SQR_CHK)
        begin
            frac_reg <= {frac_reg[LOG_FRAC-2:0], sq_shift[MUL_W]};
            x_reg    <= sq_shift[MUL_W] ? sq_shift[MUL_W:1] : sq_shift[MUL_W-1:0];
            bit_reg  <= bit_reg - 1'b1;
        end

        // The PSNR is staged here so that a result waiting on a stall keeps its payload.
        if (scale_pend_reg)
        begin
            psnr_reg <= psnr_sat;
        end

        if ((state_reg == ST_DELIVER) && res_free && !scale_pend_reg)
        begin
            res_mse_reg   <= mse_reg;
            res_psnr_reg  <= psnr_reg;
            res_inf_reg   <= inf_reg;
            res_range_reg <= flag_range_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign mse_value     = res_mse_reg;
    assign psnr_db       = res_psnr_reg;
    assign psnr_infinite = res_inf_reg;
    assign range_error   = res_range_reg;

    `IMSE_ASSERT_IMPL(a_inf_psnr_zero, res_valid && psnr_infinite, psnr_db == '0, "infinite PSNR with nonzero dB")
    `IMSE_ASSERT_IMPL(a_div_done_state, div_done, state_reg == ST_DIVIDE, "divider finished outside divide step")
    `IMSE_ASSERT_NEXT(a_clear_after_load, state_reg == ST_DIV_LOAD, (sum_reg == '0) && (count_reg == '0) && !range_reg, "accumulators not cleared")
    `IMSE_ASSERT_IMPL(a_norm_nonzero, state_reg == ST_NORM, x_reg != '0, "normalizing a zero mean")

endmodule

`default_nettype wire
